### hw/rtl/vpa_pkg.sv
// Package for the variable partition allocator.
// Request and response types, action codes and status codes. No dependencies.
`timescale 1ns / 1ps

package vpa_pkg;

    // Action codes carried in a request.
    localparam logic [1:0] ACT_FIRST   = 2'd0;
    localparam logic [1:0] ACT_NEXT    = 2'd1;
    localparam logic [1:0] ACT_BEST    = 2'd2;
    localparam logic [1:0] ACT_RELEASE = 2'd3;

    // Status codes carried in a response.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFIT  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_BADREL = 2'd3;

    // Width of the size field of a request.
    localparam int SIZE_W = 11;

    typedef struct packed {
        logic [1:0]        action;
        logic [SIZE_W-1:0] request_size;
        logic [4:0]        segment_index;
    } vpa_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] granted_start;
        logic [4:0] granted_index;
    } vpa_rsp_t;

endpackage

### hw/rtl/vpa_seg_ram.sv
// Segment table storage for the variable partition allocator.
// One write port and one read port with registered read data. No dependencies.
`timescale 1ns / 1ps

module vpa_seg_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 23
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Synchronous write and synchronous read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/variable_partition_allocator.sv
// Top level of the variable partition allocator: control sequencer and segment table.
// Depends on vpa_pkg and vpa_seg_ram.
//
//   Channel | Ports                    | Carries
//   --------+--------------------------+------------------------------------
//   request | s_valid, s_ready, s_req  | action, request_size, segment_index
//   result  | m_valid, m_ready, m_rsp  | status, granted_start, granted_index
//
// One request is worked at a time; the segment table, read one entry a cycle, sets the pace.
// An allocation scans the table at one entry a cycle and then picks a segment; a split
// then shifts each entry above the chosen one up, reading and then writing it, and writes
// the two halves, the low one used and the high one free.
// A release reads the entry and both neighbors, writes it freed and merged with any free
// neighbor, and after a merge moves the entries above down. Each response is handed over
// once the output register is free. After reset the initial free segment is written first.
// A result waits in its output register while the next request is accepted.
`timescale 1ns / 1ps

module variable_partition_allocator
    import vpa_pkg::*;
#(
    parameter int MEM_UNITS    = 1024,
    parameter int MAX_SEGMENTS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  vpa_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output vpa_rsp_t m_rsp
);

    localparam int UW = $clog2(MEM_UNITS + 1);
    localparam int SW = (UW > SIZE_W) ? UW : SIZE_W;
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int JW = $clog2(MAX_SEGMENTS + 3);
    localparam int EW = 2 * UW + 1;

    typedef struct packed {
        logic          used;
        logic [UW-1:0] seg_end;
        logic [UW-1:0] seg_start;
    } entry_t;

    typedef enum logic [14:0] {
        S_INIT   = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_SCAN   = 15'b000000000000100,
        S_PICK   = 15'b000000000001000,
        S_UP_RD  = 15'b000000000010000,
        S_UP_WR  = 15'b000000000100000,
        S_UP_LO  = 15'b000000001000000,
        S_UP_HI  = 15'b000000010000000,
        S_RL_CUR = 15'b000000100000000,
        S_RL_RGT = 15'b000001000000000,
        S_RL_LFT = 15'b000010000000000,
        S_RL_DEC = 15'b000100000000000,
        S_DN_RD  = 15'b001000000000000,
        S_DN_WR  = 15'b010000000000000,
        S_FIN    = 15'b100000000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [UW-1:0]  rov_reg, rov_next;
    logic [1:0]     act_reg, act_next;
    logic [SW-1:0]  need_reg, need_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  iss_reg, iss_next;
    logic           ev_vld_reg, ev_vld_next;
    logic [AW-1:0]  ev_idx_reg, ev_idx_next;
    logic           begin_seen_reg, begin_seen_next;
    logic           fo_found_reg, fo_found_next;
    logic [AW-1:0]  fo_idx_reg, fo_idx_next;
    entry_t         fo_ent_reg, fo_ent_next;
    logic           ab_found_reg, ab_found_next;
    logic [AW-1:0]  ab_idx_reg, ab_idx_next;
    entry_t         ab_ent_reg, ab_ent_next;
    logic           bf_found_reg, bf_found_next;
    logic [AW-1:0]  bf_idx_reg, bf_idx_next;
    entry_t         bf_ent_reg, bf_ent_next;
    logic [AW-1:0]  k_reg, k_next;
    entry_t         k_ent_reg, k_ent_next;
    entry_t         cur_reg, cur_next;
    entry_t         rgt_reg, rgt_next;
    logic [JW-1:0]  j_reg, j_next;
    logic [1:0]     d_reg, d_next;
    vpa_rsp_t       pend_reg, pend_next;
    logic           out_valid_reg, out_valid_next;
    vpa_rsp_t       rsp_reg, rsp_next;

    // Table port signals.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_ent;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_raw;
    entry_t        q;

    // Scan and decision helpers.
    logic [UW-1:0] q_size;
    logic [UW-1:0] bf_size;
    logic          q_fit;
    logic          begin_now;
    logic          sel_found;
    logic [AW-1:0] sel_idx;
    entry_t        sel_ent;
    logic [UW-1:0] sel_size;
    logic [UW-1:0] split;
    logic          lfree;
    logic          rfree;
    logic [AW-1:0] tgt;

    vpa_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (EW)
    ) u_seg_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign q       = entry_t'(rd_raw);
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_rsp   = rsp_reg;

    // Fit test on the entry returned by the table.
    assign q_size    = q.seg_end - q.seg_start;
    assign bf_size   = bf_ent_reg.seg_end - bf_ent_reg.seg_start;
    assign q_fit     = !q.used && (SW'(q_size) >= need_reg);
    assign begin_now = begin_seen_reg || (q.seg_end > rov_reg);
    assign split     = k_ent_reg.seg_start + UW'(need_reg);

    // Candidate chosen by the placement policy.
    always_comb begin
        case (act_reg)
            ACT_FIRST: begin
                sel_found = fo_found_reg;
                sel_idx   = fo_idx_reg;
                sel_ent   = fo_ent_reg;
            end
            ACT_NEXT: begin
                sel_found = ab_found_reg || fo_found_reg;
                sel_idx   = ab_found_reg ? ab_idx_reg : fo_idx_reg;
                sel_ent   = ab_found_reg ? ab_ent_reg : fo_ent_reg;
            end
            default: begin
                sel_found = bf_found_reg;
                sel_idx   = bf_idx_reg;
                sel_ent   = bf_ent_reg;
            end
        endcase
    end

    assign sel_size = sel_ent.seg_end - sel_ent.seg_start;

    // Merge decision for a release, taken when the left neighbor arrives.
    assign lfree = (idx_reg != '0) && !q.used;
    assign rfree = ((32'(idx_reg) + 1) < 32'(count_reg)) && !rgt_reg.used;
    assign tgt   = lfree ? (idx_reg - AW'(1)) : idx_reg;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rov_next        = rov_reg;
        act_next        = act_reg;
        need_next       = need_reg;
        idx_next        = idx_reg;
        iss_next        = iss_reg;
        ev_vld_next     = 1'b0;
        ev_idx_next     = ev_idx_reg;
        begin_seen_next = begin_seen_reg;
        fo_found_next   = fo_found_reg;
        fo_idx_next     = fo_idx_reg;
        fo_ent_next     = fo_ent_reg;
        ab_found_next   = ab_found_reg;
        ab_idx_next     = ab_idx_reg;
        ab_ent_next     = ab_ent_reg;
        bf_found_next   = bf_found_reg;
        bf_idx_next     = bf_idx_reg;
        bf_ent_next     = bf_ent_reg;
        k_next          = k_reg;
        k_ent_next      = k_ent_reg;
        cur_next        = cur_reg;
        rgt_next        = rgt_reg;
        j_next          = j_reg;
        d_next          = d_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_ent          = '0;
        rd_addr         = '0;

        case (state_reg)
            S_INIT: begin
                // Write the single free segment that covers all of memory.
                wr_en             = 1'b1;
                wr_ent.seg_start  = '0;
                wr_ent.seg_end    = UW'(MEM_UNITS);
                wr_ent.used       = 1'b0;
                state_next        = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    act_next        = s_req.action;
                    need_next       = SW'(s_req.request_size);
                    idx_next        = AW'(s_req.segment_index);
                    iss_next        = '0;
                    begin_seen_next = 1'b0;
                    fo_found_next   = 1'b0;
                    ab_found_next   = 1'b0;
                    bf_found_next   = 1'b0;
                    pend_next       = '0;
                    if (s_req.action == ACT_RELEASE) begin
                        if (32'(s_req.segment_index) >= 32'(count_reg)) begin
                            pend_next.status = STAT_BADREL;
                            state_next       = S_FIN;
                        end else begin
                            state_next = S_RL_CUR;
                        end
                    end else if (s_req.request_size == '0) begin
                        pend_next.status = STAT_NOFIT;
                        state_next       = S_FIN;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read a cycle and evaluate the entry read the cycle before.
                rd_addr = iss_reg[AW-1:0];
                if (iss_reg < count_reg) begin
                    ev_vld_next = 1'b1;
                    ev_idx_next = iss_reg[AW-1:0];
                    iss_next    = iss_reg + CW'(1);
                end
                if (ev_vld_reg) begin
                    begin_seen_next = begin_now;
                    if (q_fit && !fo_found_reg) begin
                        fo_found_next = 1'b1;
                        fo_idx_next   = ev_idx_reg;
                        fo_ent_next   = q;
                    end
                    if (q_fit && begin_now && !ab_found_reg) begin
                        ab_found_next = 1'b1;
                        ab_idx_next   = ev_idx_reg;
                        ab_ent_next   = q;
                    end
                    if (q_fit && (!bf_found_reg || (q_size < bf_size))) begin
                        bf_found_next = 1'b1;
                        bf_idx_next   = ev_idx_reg;
                        bf_ent_next   = q;
                    end
                end else if (iss_reg >= count_reg) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                k_next     = sel_idx;
                k_ent_next = sel_ent;
                j_next     = JW'(count_reg);
                if (!sel_found) begin
                    pend_next.status = STAT_NOFIT;
                    state_next       = S_FIN;
                end else if (SW'(sel_size) == need_reg) begin
                    // Exact fit: mark the segment used, no split.
                    wr_en                   = 1'b1;
                    wr_addr                 = sel_idx;
                    wr_ent                  = sel_ent;
                    wr_ent.used             = 1'b1;
                    rov_next                = sel_ent.seg_end;
                    pend_next.status        = STAT_OK;
                    pend_next.granted_start = 10'(sel_ent.seg_start);
                    pend_next.granted_index = 5'(sel_idx);
                    state_next              = S_FIN;
                end else if (count_reg == CW'(MAX_SEGMENTS)) begin
                    pend_next.status = STAT_FULL;
                    state_next       = S_FIN;
                end else begin
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD: begin
                // Open a slot above the chosen segment, top entry first.
                if (j_reg > (JW'(k_reg) + JW'(1))) begin
                    rd_addr    = AW'(j_reg - JW'(1));
                    state_next = S_UP_WR;
                end else begin
                    state_next = S_UP_LO;
                end
            end
            S_UP_WR: begin
                wr_en      = 1'b1;
                wr_addr    = AW'(j_reg);
                wr_ent     = q;
                j_next     = j_reg - JW'(1);
                state_next = S_UP_RD;
            end
            S_UP_LO: begin
                wr_en            = 1'b1;
                wr_addr          = k_reg;
                wr_ent.seg_start = k_ent_reg.seg_start;
                wr_ent.seg_end   = split;
                wr_ent.used      = 1'b1;
                state_next       = S_UP_HI;
            end
            S_UP_HI: begin
                wr_en                   = 1'b1;
                wr_addr                 = k_reg + AW'(1);
                wr_ent.seg_start        = split;
                wr_ent.seg_end          = k_ent_reg.seg_end;
                wr_ent.used             = 1'b0;
                count_next              = count_reg + CW'(1);
                rov_next                = split;
                pend_next.status        = STAT_OK;
                pend_next.granted_start = 10'(k_ent_reg.seg_start);
                pend_next.granted_index = 5'(k_reg);
                state_next              = S_FIN;
            end
            S_RL_CUR: begin
                rd_addr    = idx_reg;
                state_next = S_RL_RGT;
            end
            S_RL_RGT: begin
                cur_next   = q;
                rd_addr    = idx_reg + AW'(1);
                state_next = S_RL_LFT;
            end
            S_RL_LFT: begin
                rgt_next   = q;
                rd_addr    = idx_reg - AW'(1);
                state_next = S_RL_DEC;
            end
            S_RL_DEC: begin
                if (!cur_reg.used) begin
                    pend_next.status = STAT_BADREL;
                    state_next       = S_FIN;
                end else begin
                    // Write the merged free segment, then close the gap above it.
                    wr_en            = 1'b1;
                    wr_addr          = tgt;
                    wr_ent.seg_start = lfree ? q.seg_start : cur_reg.seg_start;
                    wr_ent.seg_end   = rfree ? rgt_reg.seg_end : cur_reg.seg_end;
                    wr_ent.used      = 1'b0;
                    d_next           = 2'({1'b0, lfree} + {1'b0, rfree});
                    j_next           = JW'(tgt) + JW'(1) + JW'(lfree) + JW'(rfree);
                    state_next       = S_DN_RD;
                end
            end
            S_DN_RD: begin
                // Entries above move down only when a merge removed some.
                if ((d_reg != '0) && (j_reg < JW'(count_reg))) begin
                    rd_addr    = AW'(j_reg);
                    state_next = S_DN_WR;
                end else begin
                    count_next       = count_reg - CW'(d_reg);
                    pend_next.status = STAT_OK;
                    state_next       = S_FIN;
                end
            end
            S_DN_WR: begin
                wr_en      = 1'b1;
                wr_addr    = AW'(j_reg - JW'(d_reg));
                wr_ent     = q;
                j_next     = j_reg + JW'(1);
                state_next = S_DN_RD;
            end
            S_FIN: begin
                // Hand the response over once the output register is free.
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    rsp_next       = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            count_reg     <= CW'(1);
            rov_reg       <= '0;
            ev_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rov_reg       <= rov_next;
            ev_vld_reg    <= ev_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        need_reg       <= need_next;
        idx_reg        <= idx_next;
        iss_reg        <= iss_next;
        ev_idx_reg     <= ev_idx_next;
        begin_seen_reg <= begin_seen_next;
        fo_found_reg   <= fo_found_next;
        fo_idx_reg     <= fo_idx_next;
        fo_ent_reg     <= fo_ent_next;
        ab_found_reg   <= ab_found_next;
        ab_idx_reg     <= ab_idx_next;
        ab_ent_reg     <= ab_ent_next;
        bf_found_reg   <= bf_found_next;
        bf_idx_reg     <= bf_idx_next;
        bf_ent_reg     <= bf_ent_next;
        k_reg          <= k_next;
        k_ent_reg      <= k_ent_next;
        cur_reg        <= cur_next;
        rgt_reg        <= rgt_next;
        j_reg          <= j_next;
        d_reg          <= d_next;
        pend_reg       <= pend_next;
        rsp_reg        <= rsp_next;
    end

    // The table always holds at least one and at most MAX_SEGMENTS segments.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (32'(count_reg) <= MAX_SEGMENTS))
        else $error("segment count out of range");

    // The roving address never passes the end of memory.
    a_rov_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(rov_reg) <= MEM_UNITS)
        else $error("roving address out of range");

    // Table writes land at most one place past the last live entry.
    a_wr_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (32'(wr_addr) <= 32'(count_reg)))
        else $error("table write beyond live entries");

    // A new response appears only from the hand-over state.
    a_rsp_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> ($past(state_reg) == S_FIN))
        else $error("response raised outside hand-over");

    // An evaluated scan entry always lies inside the table.
    a_scan_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && ev_vld_reg) |-> (32'(ev_idx_reg) < 32'(count_reg)))
        else $error("scan read past the table");

endmodule

### bench/vpa_checker.sv
// Checker for the variable partition allocator: watches both channels, predicts each
// response from its own copy of the segment table and compares. Depends on vpa_pkg.
`timescale 1ns / 1ps

module vpa_checker
    import vpa_pkg::*;
#(
    parameter int MEM_UNITS    = 1024,
    parameter int MAX_SEGMENTS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  vpa_req_t s_req,
    input  logic     m_valid,
    input  logic     m_ready,
    input  vpa_rsp_t m_rsp,
    output int       fail_count,
    output int       pending_count,
    output int       table_count
);

    // Shadow segment table.
    int unsigned seg_lo   [MAX_SEGMENTS];
    int unsigned seg_hi   [MAX_SEGMENTS];
    bit          seg_busy [MAX_SEGMENTS];
    int unsigned seg_total;
    int unsigned rover;

    vpa_rsp_t expected_rsps[$];

    assign pending_count = expected_rsps.size();
    assign table_count   = seg_total;

    function automatic bit seg_fits(int unsigned i, int unsigned need);
        return !seg_busy[i] && (seg_hi[i] - seg_lo[i] >= need);
    endfunction

    function automatic void drop_entry(int unsigned k);
        for (int unsigned i = k; i + 1 < seg_total; i++) begin
            seg_lo[i]   = seg_lo[i+1];
            seg_hi[i]   = seg_hi[i+1];
            seg_busy[i] = seg_busy[i+1];
        end
        seg_total--;
    endfunction

    // Pick a segment by the requested policy; MAX_SEGMENTS means none fits.
    function automatic int unsigned choose_segment(logic [1:0] act, int unsigned need);
        int unsigned pick;
        int unsigned first;
        int unsigned j;
        int unsigned best_sz;
        pick = MAX_SEGMENTS;
        first = 0;
        best_sz = 0;
        if (act == ACT_FIRST) begin
            for (int unsigned i = 0; i < seg_total; i++)
                if (pick == MAX_SEGMENTS && seg_fits(i, need)) pick = i;
        end else if (act == ACT_NEXT) begin
            for (int i = seg_total - 1; i >= 0; i--)
                if (seg_hi[i] > rover) first = i;
            for (int unsigned n = 0; n < seg_total; n++) begin
                j = first + n;
                if (j >= seg_total) j -= seg_total;
                if (pick == MAX_SEGMENTS && seg_fits(j, need)) pick = j;
            end
        end else begin
            for (int unsigned i = 0; i < seg_total; i++)
                if (seg_fits(i, need) &&
                    (pick == MAX_SEGMENTS || seg_hi[i] - seg_lo[i] < best_sz)) begin
                    pick = i;
                    best_sz = seg_hi[i] - seg_lo[i];
                end
        end
        return pick;
    endfunction

    // Apply one request to the shadow table and return its response.
    function automatic vpa_rsp_t predict_response(vpa_req_t req);
        vpa_rsp_t    rsp;
        int unsigned k;
        int unsigned idx;
        int unsigned need;
        rsp = '0;
        rsp.status = STAT_OK;
        idx = req.segment_index;
        need = req.request_size;
        if (req.action == ACT_RELEASE) begin
            if (idx >= seg_total || !seg_busy[idx]) begin
                rsp.status = STAT_BADREL;
            end else begin
                seg_busy[idx] = 0;
                if (idx + 1 < seg_total && !seg_busy[idx+1]) begin
                    seg_hi[idx] = seg_hi[idx+1];
                    drop_entry(idx + 1);
                end
                if (idx > 0 && !seg_busy[idx-1]) begin
                    seg_hi[idx-1] = seg_hi[idx];
                    drop_entry(idx);
                end
            end
        end else begin
            k = (need == 0) ? MAX_SEGMENTS : choose_segment(req.action, need);
            if (k >= seg_total) begin
                rsp.status = STAT_NOFIT;
            end else if (seg_hi[k] - seg_lo[k] == need) begin
                seg_busy[k] = 1;
                rsp.granted_start = 10'(seg_lo[k]);
                rsp.granted_index = 5'(k);
                rover = seg_hi[k];
            end else if (seg_total >= MAX_SEGMENTS) begin
                rsp.status = STAT_FULL;
            end else begin
                for (int unsigned i = seg_total; i > k; i--) begin
                    seg_lo[i]   = seg_lo[i-1];
                    seg_hi[i]   = seg_hi[i-1];
                    seg_busy[i] = seg_busy[i-1];
                end
                seg_total++;
                seg_hi[k] = seg_lo[k] + need;
                seg_busy[k] = 1;
                seg_lo[k+1] = seg_hi[k];
                seg_busy[k+1] = 0;
                rsp.granted_start = 10'(seg_lo[k]);
                rsp.granted_index = 5'(k);
                rover = seg_hi[k];
            end
        end
        return rsp;
    endfunction

    // Predict on accepted requests, compare on accepted responses.
    always @(posedge aclk) begin
        vpa_rsp_t want;
        if (!aresetn) begin
            fail_count <= 0;
            expected_rsps.delete();
            for (int i = 0; i < MAX_SEGMENTS; i++) begin
                seg_lo[i] = 0;
                seg_hi[i] = 0;
                seg_busy[i] = 0;
            end
            seg_hi[0] = MEM_UNITS;
            seg_total = 1;
            rover = 0;
        end else begin
            if (s_valid && s_ready)
                expected_rsps.insert(expected_rsps.size(), predict_response(s_req));
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected response %p at %0t", m_rsp, $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want !== m_rsp) begin
                        if (fail_count < 10)
                            $display("Response mismatch at %0t: expected %p, got %p",
                                     $realtime, want, m_rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### bench/variable_partition_allocator_tb.sv
// Testbench top for the variable partition allocator: clock, reset, request stimulus
// and verdict. Depends on vpa_pkg, the allocator RTL and vpa_checker.
`timescale 1ns / 1ps

module variable_partition_allocator_tb;
    import vpa_pkg::*;

    localparam int MEM_UNITS    = 1024;
    localparam int MAX_SEGMENTS = 32;
    localparam int CYCLE_LIMIT  = 600000;

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    vpa_req_t s_req = '0;
    logic     m_valid;
    logic     m_ready = 0;
    vpa_rsp_t m_rsp;
    int       fail_count;
    int       pending_count;
    int       table_count;
    int       cycle_count = 0;
    bit       hold_off = 0;

    always #4 aclk = ~aclk;

    variable_partition_allocator #(
        .MEM_UNITS(MEM_UNITS), .MAX_SEGMENTS(MAX_SEGMENTS)
    ) uut (.*);

    vpa_checker #(
        .MEM_UNITS(MEM_UNITS), .MAX_SEGMENTS(MAX_SEGMENTS)
    ) checker_i (.*);

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("variable_partition_allocator test failed");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // Response side: random stalls, one long hold-off on request.
    initial begin
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (cycle_count > 200000) stall = 0;
            if (stall != 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    // Present one request and wait for acceptance, with an optional gap first.
    task automatic send_request(logic [1:0] act, int unsigned sz, int unsigned idx,
                                bit gaps);
        int unsigned gap;
        gap = gaps ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_req.action <= act;
        s_req.request_size <= SIZE_W'(sz);
        s_req.segment_index <= 5'(idx);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic int unsigned rand_size();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 2047);
            1: return 0;
            2: return $urandom_range(200, 1024);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    initial begin
        logic [1:0] act;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: zero size, oversize, exact fit of the whole memory, bad releases,
        // merges on both sides, each policy.
        send_request(ACT_FIRST, 0, 0, 0);
        send_request(ACT_BEST, 2047, 31, 0);
        send_request(ACT_RELEASE, 0, 0, 0);
        send_request(ACT_RELEASE, 0, 31, 0);
        send_request(ACT_NEXT, 1024, 0, 0);
        send_request(ACT_FIRST, 1, 0, 0);
        send_request(ACT_RELEASE, 0, 0, 0);
        send_request(ACT_FIRST, 100, 0, 0);
        send_request(ACT_FIRST, 50, 0, 0);
        send_request(ACT_FIRST, 200, 0, 0);
        send_request(ACT_RELEASE, 0, 1, 0);
        send_request(ACT_BEST, 40, 0, 0);
        send_request(ACT_NEXT, 10, 0, 0);
        send_request(ACT_NEXT, 1000, 0, 0);
        send_request(ACT_RELEASE, 0, 0, 0);
        send_request(ACT_RELEASE, 0, 2, 0);
        send_request(ACT_RELEASE, 0, 1, 0);
        send_request(ACT_RELEASE, 0, 0, 0);
        // Fill the table with small splits to reach the full case.
        for (int i = 0; i < 33; i++) send_request(ACT_FIRST, 1, 0, 0);
        send_request(ACT_BEST, 5, 0, 0);
        send_request(ACT_NEXT, 3, 0, 0);

        // Long receiver hold-off while requests keep coming.
        hold_off = 1;
        for (int i = 0; i < 30; i++) send_request(ACT_RELEASE, 0, $urandom_range(0, 31), 0);

        // Random traffic, releases weighted up as the table fills.
        for (int i = 0; i < 900; i++) begin
            if ($urandom_range(0, 99) < (table_count > 20 ? 60 : 35)) act = ACT_RELEASE;
            else act = 2'($urandom_range(0, 2));
            send_request(act, rand_size(),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                             : $urandom_range(0, table_count > 0 ? table_count - 1 : 0),
                         ($urandom_range(0, 3) != 0) && (i < 400 || i > 600));
        end
        s_valid <= 0;

        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("variable_partition_allocator test passed");
        else
            $display("variable_partition_allocator test failed");
        $finish;
    end

endmodule
